FILE: src/timetable_earliest_arrival_macros.svh
// assertion macros shared by the timetable earliest-arrival rtl
`ifndef TIMETABLE_EARLIEST_ARRIVAL_MACROS_SVH
`define TIMETABLE_EARLIEST_ARRIVAL_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define TEA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("tea check failed");

// next-cycle implication, off while reset is asserted
`define TEA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("tea check failed");

`endif

FILE: src/tea_pkg.sv
// shared constants, types and hour arithmetic for the earliest-arrival block
package tea_pkg;

	localparam int HOURS_PER_DAY = 24;
	localparam int RES_W         = 5;
	localparam int EP_W          = 8;
	localparam int OUT_TIME_W    = 24;
	localparam int STOP_W        = 8;
	localparam int TRAV_W        = 10;
	localparam int HOUR_W        = 5;
	localparam int CFG_DATA_W    = 8;
	localparam int CFG_IDX_W     = 1;

	// epoch tags; tag zero marks a swept entry and is never current
	localparam logic [EP_W-1:0] EP_FIRST = EP_W'(1);
	localparam logic [EP_W-1:0] EP_LAST  = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_HOUR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [OUT_TIME_W-1:0] arr_time;
		logic                  unreach;
	} res_t;

	typedef struct packed {
		logic s1_final;
		logic s2_final;
	} pipe_stat_t;

	// value below 72 reduced to hour of day
	function automatic logic [RES_W-1:0] mod24_lt72(input logic [6:0] x);
		logic [6:0] y;
		y = x;
		if (y >= 7'(2 * HOURS_PER_DAY))
			y = y - 7'(2 * HOURS_PER_DAY);
		if (y >= 7'(HOURS_PER_DAY))
			y = y - 7'(HOURS_PER_DAY);
		return y[RES_W-1:0];
	endfunction

	// travel hours mod 24: low three bits plus eight times (upper bits mod 3)
	function automatic logic [RES_W-1:0] mod24_trav(input logic [TRAV_W-1:0] t);
		logic [3:0] s;
		s = 4'(t[4:3]) + 4'(t[6:5]) + 4'(t[8:7]) + 4'(t[9]);
		if (s >= 4'd6)
			s = s - 4'd6;
		if (s >= 4'd3)
			s = s - 4'd3;
		return RES_W'({s[1:0], t[2:0]});
	endfunction

endpackage

FILE: src/tea_ram.sv
// generic simple dual-read ram with one write port and registered reads
module tea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered reads, old data on a same-edge write
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

FILE: src/tea_pipe.sv
// relax stage with write forwarding, and final-stop lookup stage
`include "timetable_earliest_arrival_macros.svh"

module tea_pipe #(
	parameter int IDX_W     = 8,
	parameter int TIME_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc,
	input  logic                              rel_ok,
	input  logic [IDX_W-1:0]                  orig_idx,
	input  logic [IDX_W-1:0]                  dest_idx,
	input  logic [tea_pkg::HOUR_W-1:0]        dep_hour,
	input  logic [tea_pkg::TRAV_W-1:0]        trav,
	input  logic [tea_pkg::RES_W-1:0]         trav_res,
	input  logic                              fin,
	input  logic [tea_pkg::HOUR_W-1:0]        start_hour,
	input  logic [IDX_W-1:0]                  fin_idx,
	input  logic                              fin_ok,
	input  logic [tea_pkg::EP_W-1:0]          epoch,
	input  logic [tea_pkg::EP_W+tea_pkg::RES_W+TIME_BITS-1:0] rd_a,
	input  logic [tea_pkg::EP_W+tea_pkg::RES_W+TIME_BITS-1:0] rd_b,
	output logic                              wr_en,
	output logic [IDX_W-1:0]                  wr_addr,
	output logic [tea_pkg::EP_W+tea_pkg::RES_W+TIME_BITS-1:0] wr_data,
	output tea_pkg::pipe_stat_t               stat,
	output logic                              res_valid,
	output tea_pkg::res_t                     res
);

	import tea_pkg::*;

	localparam int SUM_W = TIME_BITS + 12;
	localparam logic [RES_W-1:0] SAT_RES =
		RES_W'(((64'd1 << TIME_BITS) - 64'd1) % 64'(HOURS_PER_DAY));

	// stage 1 registers
	logic                  v_s1;
	logic                  fin_s1;
	logic                  ok_s1;
	logic [IDX_W-1:0]      oidx_s1;
	logic [IDX_W-1:0]      didx_s1;
	logic [HOUR_W-1:0]     dep_s1;
	logic [TRAV_W-1:0]     trav_s1;
	logic [RES_W-1:0]      tres_s1;
	logic                  v_s2;

	// last write, for forwarding into the next read
	logic                  wq_en_q;
	logic [IDX_W-1:0]      wq_addr_q;
	logic [TIME_BITS-1:0]  wq_time_q;
	logic [RES_W-1:0]      wq_res_q;

	logic                  fwd_o;
	logic                  fwd_d;
	logic                  fwd_f;
	logic                  o_reach;
	logic [TIME_BITS-1:0]  o_time;
	logic [RES_W-1:0]      o_res;
	logic                  d_reach;
	logic [TIME_BITS-1:0]  d_time;
	logic                  f_reach;
	logic [TIME_BITS-1:0]  f_time;
	logic [RES_W-1:0]      hod;
	logic [RES_W-1:0]      wait_h;
	logic [SUM_W-1:0]      sum;
	logic                  sat;
	logic [TIME_BITS-1:0]  t_new;
	logic [RES_W-1:0]      r_new;
	logic                  upd;

	// valid bits for both stages and the forwarding write enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			wq_en_q <= 1'b0;
		end else begin
			v_s1    <= acc;
			v_s2    <= v_s1 && fin_s1;
			wq_en_q <= upd;
		end
	end

	// stage 1 payload and forwarding payload
	always_ff @(posedge clk) begin
		if (acc) begin
			fin_s1  <= fin;
			ok_s1   <= rel_ok;
			oidx_s1 <= orig_idx;
			didx_s1 <= dest_idx;
			dep_s1  <= dep_hour;
			trav_s1 <= trav;
			tres_s1 <= trav_res;
		end
		wq_addr_q <= didx_s1;
		wq_time_q <= t_new;
		wq_res_q  <= r_new;
	end

	// origin entry, forwarded from the last write; stop one is always at zero
	always_comb begin
		fwd_o   = wq_en_q && (wq_addr_q == oidx_s1);
		o_time  = fwd_o ? wq_time_q : rd_a[TIME_BITS-1:0];
		o_res   = fwd_o ? wq_res_q : rd_a[TIME_BITS +: RES_W];
		o_reach = fwd_o || (rd_a[TIME_BITS+RES_W +: EP_W] == epoch);
		if (oidx_s1 == '0) begin
			o_time  = '0;
			o_res   = '0;
			o_reach = 1'b1;
		end
	end

	// destination entry
	always_comb begin
		fwd_d   = wq_en_q && (wq_addr_q == didx_s1);
		d_time  = fwd_d ? wq_time_q : rd_b[TIME_BITS-1:0];
		d_reach = fwd_d || (rd_b[TIME_BITS+RES_W +: EP_W] == epoch);
		if (didx_s1 == '0) begin
			d_time  = '0;
			d_reach = 1'b1;
		end
	end

	// hour of day, wait, arrival and the relax decision
	always_comb begin
		hod    = mod24_lt72(7'(start_hour) + 7'(o_res));
		wait_h = mod24_lt72(7'(HOURS_PER_DAY) - 7'(hod) + 7'(dep_s1));
		sum    = SUM_W'(o_time) + SUM_W'(trav_s1) + SUM_W'(wait_h);
		sat    = |sum[SUM_W-1:TIME_BITS];
		t_new  = sat ? '1 : sum[TIME_BITS-1:0];
		r_new  = sat ? SAT_RES : mod24_lt72(7'(o_res) + 7'(wait_h) + 7'(tres_s1));
		upd    = v_s1 && ok_s1 && o_reach && (!d_reach || (t_new < d_time));
	end

	assign wr_en   = upd;
	assign wr_addr = didx_s1;
	assign wr_data = {epoch, r_new, t_new};

	// stage 2: final stop was read on port a at the end of stage 1
	always_comb begin
		fwd_f   = wq_en_q && (wq_addr_q == fin_idx);
		f_time  = fwd_f ? wq_time_q : rd_a[TIME_BITS-1:0];
		f_reach = fwd_f || (rd_a[TIME_BITS+RES_W +: EP_W] == epoch);
		if (fin_idx == '0) begin
			f_time  = '0;
			f_reach = 1'b1;
		end
		res.unreach  = !(fin_ok && f_reach);
		res.arr_time = (fin_ok && f_reach) ? OUT_TIME_W'(f_time) : '0;
	end

	assign res_valid     = v_s2;
	assign stat.s1_final = v_s1 && fin_s1;
	assign stat.s2_final = v_s2;

	`TEA_ASSERT_IMP(a_no_home_write, clk, arst_n, wr_en, wr_addr != '0)
	`TEA_ASSERT_IMP(a_bubble_after_final, clk, arst_n, v_s2, !v_s1)

endmodule

FILE: src/tea_outq.sv
// two-entry result queue between the lookup stage and the result channel
`include "timetable_earliest_arrival_macros.svh"

module tea_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tea_pkg::res_t push_data,
	output logic          valid,
	input  logic          ready,
	output tea_pkg::res_t data,
	output logic [1:0]    cnt
);

	import tea_pkg::*;

	logic v0_q;
	logic v1_q;
	res_t e0_q;
	res_t e1_q;
	logic pop;
	logic ld0_in;
	logic ld0_up;
	logic ld1_in;

	assign pop = v0_q && ready;

	// where a pushed beat lands and whether the tail moves up
	always_comb begin
		ld0_up = pop && v1_q;
		ld0_in = push && (!v0_q || (pop && !v1_q));
		ld1_in = push && v0_q && (v1_q || !pop);
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= ld0_in || ld0_up || (v0_q && !pop);
			v1_q <= ld1_in || (v1_q && !pop);
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (ld0_up) begin
			e0_q <= e1_q;
		end else if (ld0_in) begin
			e0_q <= push_data;
		end
		if (ld1_in) begin
			e1_q <= push_data;
		end
	end

	assign valid = v0_q;
	assign data  = e0_q;
	assign cnt   = 2'(v0_q) + 2'(v1_q);

	`TEA_ASSERT_IMP(a_no_overflow, clk, arst_n, push && v1_q, pop)
	`TEA_ASSERT_IMP(a_fill_order, clk, arst_n, v1_q, v0_q)

endmodule

FILE: src/timetable_earliest_arrival.sv
// Earliest arrival over a chain of stops with departures on a 24-hour cycle.
// Departure channel (dep_valid/dep_ready): one beat per departure, grouped by
// ascending origin; the beat with final_item set closes the problem.
// Result channel (res_valid/res_ready): one beat per final_item, carrying the
// best time at stop stop_count+1 and an unreachable flag.
// Config port: cfg_we with cfg_index 0 = start_hour, 1 = stop_count; write only
// between problems.
// Throughput: one departure per cycle while dep_ready is high. Each departure
// is one read-modify-write of the best-time ram, with the last write forwarded
// to the next reads. After a final beat dep_ready stays low while the final
// stop is read on port a; results pass stage 1, stage 2 and the result queue.
// Best times are tagged with a problem epoch, so a new problem starts clean
// at once. After reset, and after every 255th problem, a sweep rewrites all
// tags; dep_ready stays low while it runs.
// A stalled result channel holds up to two results; with both slots in use
// or reserved, dep_ready drops until one is taken.
`include "timetable_earliest_arrival_macros.svh"

module timetable_earliest_arrival #(
	parameter int MAX_STOPS = 256,
	parameter int TIME_BITS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tea_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tea_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              dep_valid,
	output logic                              dep_ready,
	input  logic [tea_pkg::STOP_W-1:0]        origin_stop,
	input  logic [tea_pkg::STOP_W-1:0]        hop_count,
	input  logic [tea_pkg::HOUR_W-1:0]        depart_hour,
	input  logic [tea_pkg::TRAV_W-1:0]        travel_hours,
	input  logic                              final_item,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [tea_pkg::OUT_TIME_W-1:0]    arrival_time,
	output logic                              unreachable
);

	import tea_pkg::*;

	localparam int IDX_W = $clog2(MAX_STOPS);
	localparam int WORD_W = EP_W + RES_W + TIME_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_STOPS - 1);

	logic [HOUR_W-1:0] start_hour_q;
	logic [STOP_W-1:0] stop_count_q;
	logic [EP_W-1:0]   epoch_q;
	logic              clr_busy_q;
	logic [IDX_W-1:0]  clr_idx_q;

	logic              acc;
	logic [STOP_W:0]   dest_s0;
	logic [STOP_W:0]   final_stop;
	logic              rel_ok_s0;
	logic [IDX_W-1:0]  orig_idx_s0;
	logic [IDX_W-1:0]  dest_idx_s0;
	logic [RES_W-1:0]  trav_res_s0;
	logic [IDX_W-1:0]  fin_idx;
	logic              fin_ok;

	logic              p_wr_en;
	logic [IDX_W-1:0]  p_wr_addr;
	logic [WORD_W-1:0] p_wr_data;
	logic              m_we;
	logic [IDX_W-1:0]  m_waddr;
	logic [WORD_W-1:0] m_wdata;
	logic [IDX_W-1:0]  m_raddr_a;
	logic [WORD_W-1:0] rd_a;
	logic [WORD_W-1:0] rd_b;

	pipe_stat_t        stat;
	logic              p_res_valid;
	res_t              p_res;
	res_t              q_data;
	logic [1:0]        q_cnt;
	logic [2:0]        occ;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hour_q <= '0;
			stop_count_q <= STOP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_HOUR: start_hour_q <= cfg_data[HOUR_W-1:0];
				REG_STOP_COUNT: stop_count_q <= cfg_data[STOP_W-1:0];
				default: ;
			endcase
		end
	end

	// departure decode: range checks and ram indexes
	always_comb begin
		dest_s0     = {1'b0, origin_stop} + {1'b0, hop_count};
		final_stop  = {1'b0, stop_count_q} + (STOP_W+1)'(1);
		rel_ok_s0   = (origin_stop != '0) && (32'(origin_stop) <= 32'(MAX_STOPS)) &&
			(dest_s0 <= final_stop) && (32'(dest_s0) <= 32'(MAX_STOPS));
		orig_idx_s0 = IDX_W'(origin_stop - STOP_W'(1));
		dest_idx_s0 = IDX_W'(dest_s0 - (STOP_W+1)'(1));
		trav_res_s0 = mod24_trav(travel_hours);
		fin_idx     = IDX_W'(stop_count_q);
		fin_ok      = 32'(stop_count_q) < 32'(MAX_STOPS);
	end

	// input handshake
	always_comb begin
		occ       = 3'(q_cnt) + 3'(stat.s2_final);
		dep_ready = !clr_busy_q && !stat.s1_final &&
			!(stat.s2_final && (epoch_q == EP_LAST)) && (occ < 3'd2);
		acc       = dep_valid && dep_ready;
	end

	// epoch advance per problem, tag sweep at reset and on epoch wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			epoch_q    <= EP_FIRST;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (clr_idx_q == LAST_IDX) begin
				clr_busy_q <= 1'b0;
				epoch_q    <= EP_FIRST;
			end
		end else if (stat.s2_final) begin
			if (epoch_q == EP_LAST) begin
				clr_busy_q <= 1'b1;
				clr_idx_q  <= '0;
			end else begin
				epoch_q <= epoch_q + EP_W'(1);
			end
		end
	end

	// ram ports: sweep owns the write port; port a reads the final stop after a final beat
	always_comb begin
		m_we      = clr_busy_q || p_wr_en;
		m_waddr   = clr_busy_q ? clr_idx_q : p_wr_addr;
		m_wdata   = clr_busy_q ? '0 : p_wr_data;
		m_raddr_a = stat.s1_final ? fin_idx : orig_idx_s0;
	end

	tea_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_STOPS)
	) u_ram (
		.clk     (clk),
		.we      (m_we),
		.waddr   (m_waddr),
		.wdata   (m_wdata),
		.raddr_a (m_raddr_a),
		.rdata_a (rd_a),
		.raddr_b (dest_idx_s0),
		.rdata_b (rd_b)
	);

	tea_pipe #(
		.IDX_W     (IDX_W),
		.TIME_BITS (TIME_BITS)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.rel_ok     (rel_ok_s0),
		.orig_idx   (orig_idx_s0),
		.dest_idx   (dest_idx_s0),
		.dep_hour   (depart_hour),
		.trav       (travel_hours),
		.trav_res   (trav_res_s0),
		.fin        (final_item),
		.start_hour (start_hour_q),
		.fin_idx    (fin_idx),
		.fin_ok     (fin_ok),
		.epoch      (epoch_q),
		.rd_a       (rd_a),
		.rd_b       (rd_b),
		.wr_en      (p_wr_en),
		.wr_addr    (p_wr_addr),
		.wr_data    (p_wr_data),
		.stat       (stat),
		.res_valid  (p_res_valid),
		.res        (p_res)
	);

	tea_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (p_res_valid),
		.push_data (p_res),
		.valid     (res_valid),
		.ready     (res_ready),
		.data      (q_data),
		.cnt       (q_cnt)
	);

	assign arrival_time = q_data.arr_time;
	assign unreachable  = q_data.unreach;

	`TEA_ASSERT_IMP(a_sweep_alone, clk, arst_n, clr_busy_q, !p_wr_en && !stat.s1_final)
	`TEA_ASSERT_NXT(a_final_holds_input, clk, arst_n, acc && final_item, !dep_ready)

endmodule

FILE: dv/tb_timetable_earliest_arrival.sv
`timescale 1ns / 100ps
// testbench for timetable_earliest_arrival: predicts every problem, checks each result beat
module tb_timetable_earliest_arrival;
	import tea_pkg::*;

	localparam int              STOPS         = 256;
	localparam int              TBITS         = 24;
	localparam longint unsigned TIME_CEIL     = (64'd1 << TBITS) - 1;
	localparam int              STALL_LIMIT   = 3000;
	localparam int              SETTLE_CYCLES = 8;
	localparam int              MAX_GAP       = 40;

	typedef struct packed {
		logic [STOP_W-1:0] origin;
		logic [STOP_W-1:0] hops;
		logic [HOUR_W-1:0] depart;
		logic [TRAV_W-1:0] travel;
		logic              is_last;
	} departure_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  dep_valid    = 1'b0;
	logic [STOP_W-1:0]     origin_stop  = '0;
	logic [STOP_W-1:0]     hop_count    = '0;
	logic [HOUR_W-1:0]     depart_hour  = '0;
	logic [TRAV_W-1:0]     travel_hours = '0;
	logic                  final_item   = 1'b0;
	logic                  res_ready    = 1'b1;
	logic                  dep_ready;
	logic                  res_valid;
	logic [OUT_TIME_W-1:0] arrival_time;
	logic                  unreachable;

	// own copy of the best-time store and the registers
	logic [TBITS-1:0]  best_hours [STOPS];
	bit                seen_stop  [STOPS];
	logic [HOUR_W-1:0] start_hour_q = '0;
	logic [STOP_W-1:0] stop_count_q = STOP_W'(1);
	res_t              arrivals_due [$];

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   hold_left      = 0;
	int   errors         = 0;
	int   stall_cycles   = 0;
	res_t got;
	res_t want;

	timetable_earliest_arrival i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.dep_valid    (dep_valid),
		.dep_ready    (dep_ready),
		.origin_stop  (origin_stop),
		.hop_count    (hop_count),
		.depart_hour  (depart_hour),
		.travel_hours (travel_hours),
		.final_item   (final_item),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.arrival_time (arrival_time),
		.unreachable  (unreachable)
	);

	always #5 clk = ~clk;

	// new problem: only stop one reached, at time zero
	function automatic void clear_best_times();
		for (int i = 0; i < STOPS; i++) begin
			best_hours[i] = '0;
			seen_stop[i]  = 1'b0;
		end
		seen_stop[0] = 1'b1;
	endfunction

	// wait for the departure, ride it, lower the destination's best time
	function automatic void relax_departure(input departure_t d);
		int unsigned     dest;
		longint unsigned here;
		longint unsigned hour_now;
		longint unsigned wait_h;
		longint unsigned t;
		dest = 32'(d.origin) + 32'(d.hops);
		if (d.origin == '0)
			return;
		if (dest > 32'(stop_count_q) + 32'd1 || dest > STOPS)
			return;
		if (!seen_stop[d.origin - 1])
			return;
		here     = 64'(best_hours[d.origin - 1]);
		hour_now = (64'(start_hour_q) + here) % 64'(HOURS_PER_DAY);
		wait_h   = (64'(HOURS_PER_DAY) - hour_now + 64'(d.depart)) % 64'(HOURS_PER_DAY);
		t        = wait_h + 64'(d.travel) + here;
		if (t > TIME_CEIL)
			t = TIME_CEIL;
		if (!seen_stop[dest - 1] || t < 64'(best_hours[dest - 1])) begin
			best_hours[dest - 1] = t[TBITS-1:0];
			seen_stop[dest - 1]  = 1'b1;
		end
	endfunction

	// one accepted departure; a last one closes the problem
	function automatic void accept_departure(input departure_t d);
		res_t        r;
		int unsigned dest_stop;
		relax_departure(d);
		if (d.is_last) begin
			dest_stop = 32'(stop_count_q) + 32'd1;
			if (dest_stop <= STOPS && seen_stop[dest_stop - 1]) begin
				r.arr_time = best_hours[dest_stop - 1][OUT_TIME_W-1:0];
				r.unreach  = 1'b0;
			end else begin
				r.arr_time = '0;
				r.unreach  = 1'b1;
			end
			arrivals_due.push_back(r);
			clear_best_times();
		end
	endfunction

	function automatic departure_t make_departure(input int o, input int h, input int dh,
			input int tr, input int last);
		departure_t d;
		d.origin  = STOP_W'(o);
		d.hops    = STOP_W'(h);
		d.depart  = HOUR_W'(dh);
		d.travel  = TRAV_W'(tr);
		d.is_last = (last != 0);
		return d;
	endfunction

	function automatic departure_t noise_departure();
		departure_t d;
		d.origin  = STOP_W'($urandom_range(0, 255));
		d.hops    = STOP_W'($urandom_range(0, 255));
		d.depart  = HOUR_W'($urandom_range(0, 31));
		d.travel  = TRAV_W'($urandom_range(0, 1023));
		d.is_last = 1'b0;
		return d;
	endfunction

	// offer one departure beat, with a random idle gap ahead of it
	task automatic send_departure(input departure_t d);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			dep_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		dep_valid    <= 1'b1;
		origin_stop  <= d.origin;
		hop_count    <= d.hops;
		depart_hour  <= d.depart;
		travel_hours <= d.travel;
		final_item   <= d.is_last;
		@(posedge clk);
		while (!dep_ready)
			@(posedge clk);
		accept_departure(d);
	endtask

	// sender pauses until every pending arrival has come back
	task automatic wait_for_arrivals();
		dep_valid <= 1'b0;
		while (arrivals_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_START_HOUR)
			start_hour_q = value[HOUR_W-1:0];
		else
			stop_count_q = value[STOP_W-1:0];
	endtask

	// start hour carries random bits above its five
	task automatic set_timetable(input int hour, input int count);
		logic [CFG_DATA_W-1:0] hour_data;
		hour_data = {3'($urandom_range(0, 7)), 5'(hour)};
		write_reg(REG_START_HOUR, hour_data);
		write_reg(REG_STOP_COUNT, CFG_DATA_W'(count));
	endtask

	// one problem: ascending origins with some noise and some out of order
	task automatic send_timetable_problem(input int n_deps);
		departure_t d;
		int         k;
		int         origin;
		int         step_max;
		int         span;
		origin   = 1;
		step_max = (2 * int'(stop_count_q)) / n_deps + 1;
		for (k = 0; k < n_deps; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				d = noise_departure();
			end else begin
				if ($urandom_range(0, 19) == 0) begin
					d.origin = STOP_W'($urandom_range(1, stop_count_q));
				end else begin
					if (k > 0)
						origin += $urandom_range(0, step_max);
					if (origin > int'(stop_count_q))
						origin = int'(stop_count_q);
					d.origin = STOP_W'(origin);
				end
				span = int'(stop_count_q) + 1 - int'(d.origin);
				case ($urandom_range(0, 3))
					0: d.hops = STOP_W'(span);
					1: d.hops = STOP_W'($urandom_range(1, span));
					default: d.hops = STOP_W'($urandom_range(1, span < 4 ? span : 4));
				endcase
				if ($urandom_range(0, 7) == 0)
					d.depart = HOUR_W'($urandom_range(24, 31));
				else
					d.depart = HOUR_W'($urandom_range(0, 23));
				if ($urandom_range(0, 3) == 0)
					d.travel = TRAV_W'($urandom_range(0, 1023));
				else
					d.travel = TRAV_W'($urandom_range(0, 40));
			end
			d.is_last = (k == n_deps - 1);
			send_departure(d);
		end
	endtask

	// edges of every field and each named corner of the relaxation
	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// reset settings: one hop straight to the final stop
		send_departure(make_departure(1, 1, 5, 7, 1));
		wait_for_arrivals();

		set_timetable(0, 5);
		send_departure(make_departure(1, 1, 3, 2, 0));
		// origin zero
		send_departure(make_departure(0, 1, 0, 0, 0));
		// zero hops onto its own origin
		send_departure(make_departure(1, 0, 0, 0, 0));
		// destination beyond the final stop and the store
		send_departure(make_departure(2, 255, 0, 0, 0));
		// origin never reached
		send_departure(make_departure(3, 1, 0, 0, 0));
		// hour above the day, longest trip
		send_departure(make_departure(2, 4, 31, 1023, 0));
		send_departure(make_departure(1, 5, 0, 0, 0));
		send_departure(make_departure(255, 255, 23, 1023, 1));
		wait_for_arrivals();

		// final stop left unreached
		send_departure(make_departure(1, 1, 0, 0, 1));
		wait_for_arrivals();

		set_timetable(31, 255);
		send_departure(make_departure(1, 255, 0, 1023, 0));
		send_departure(make_departure(1, 128, 23, 0, 0));
		send_departure(make_departure(128, 128, 0, 0, 0));
		send_departure(make_departure(129, 127, 31, 1023, 0));
		send_departure(make_departure(129, 200, 0, 0, 0));
		send_departure(make_departure(255, 1, 0, 0, 0));
		send_departure(make_departure(0, 0, 0, 0, 1));
		wait_for_arrivals();
	endtask

	// random problems over all idle patterns and several register settings
	task automatic test_random_timetables();
		int m;
		int s;
		int n;
		int sent;
		int problems;
		for (m = 0; m < 4; m++) begin
			case (m)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			for (s = 0; s < 5; s++) begin
				case (s)
					0: set_timetable(0, 1);
					1: set_timetable(23, 255);
					2: set_timetable(31, $urandom_range(2, 12));
					3: set_timetable($urandom_range(0, 31), $urandom_range(1, 255));
					default: set_timetable($urandom_range(0, 23), $urandom_range(2, 6));
				endcase
				sent     = 0;
				problems = 0;
				while (sent < 25) begin
					if (stop_count_q > 16)
						n = $urandom_range(1, 30);
					else
						n = $urandom_range(1, 10);
					send_timetable_problem(n);
					sent += n;
					if (problems == 0 || $urandom_range(0, 7) == 0)
						wait_for_arrivals();
					problems++;
				end
				wait_for_arrivals();
			end
		end
	endtask

	// receiver holds off long enough for the result slots to fill and stall input
	task automatic test_result_backpressure();
		int p;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		set_timetable(5, 3);
		hold_left = 400;
		for (p = 0; p < 24; p++)
			send_timetable_problem($urandom_range(1, 3));
		wait_for_arrivals();
	endtask

	// enough short problems to wrap the epoch tags and trigger a sweep
	task automatic test_epoch_rollover();
		int p;
		send_idle_pct  = 15;
		recv_stall_pct = 15;
		set_timetable($urandom_range(0, 23), 2);
		for (p = 0; p < 270; p++)
			send_timetable_problem($urandom_range(1, 2));
		wait_for_arrivals();
	endtask

	// result beats: compare against the oldest pending arrival
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			got.arr_time = arrival_time;
			got.unreach  = unreachable;
			if (arrivals_due.size() == 0) begin
				$display("%0t: result arrival_time %0d unreachable %0b with none expected",
					$time, got.arr_time, got.unreach);
				errors++;
			end else begin
				want = arrivals_due.pop_front();
				if (got.arr_time !== want.arr_time) begin
					$display("%0t: arrival_time expected %0d actual %0d",
						$time, want.arr_time, got.arr_time);
					errors++;
				end
				if (got.unreach !== want.unreach) begin
					$display("%0t: unreachable expected %0b actual %0b",
						$time, want.unreach, got.unreach);
					errors++;
				end
			end
		end
	end

	// receiver: long hold when asked, random stalls otherwise
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no beat on any port
	always @(posedge clk) begin
		if (!arst_n || (dep_valid && dep_ready) || (res_valid && res_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, stall_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		clear_best_times();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_timetables();
		test_result_backpressure();
		test_epoch_rollover();
		wait_for_arrivals();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+src
src/tea_pkg.sv
src/tea_ram.sv
src/tea_pipe.sv
src/tea_outq.sv
src/timetable_earliest_arrival.sv
dv/tb_timetable_earliest_arrival.sv
